/* hw/rtl/ppra_pkg.sv */
// Package for the preemptive priority request arbiter.
// Holds item kinds, result status codes, controller states and command structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ppra_pkg;

   localparam int DefQueueDepth = 16;
   localparam int DefDedupDepth = 16;
   localparam int DefTagBits    = 16;

   localparam int PrioW   = 8;
   localparam int TypeW   = 3;
   localparam int FieldTagW = 16;
   localparam int KeyW    = 64;
   localparam int TimeW   = 32;
   localparam int GapW    = 16;
   localparam int LevelW  = 5;
   localparam int AddrW   = 5;
   localparam int DataW   = 32;

   localparam logic [2:0] RegDedupEnable  = 3'd0;
   localparam logic [2:0] RegFilterEnable = 3'd1;
   localparam logic [2:0] RegDupGap       = 3'd2;
   localparam logic [2:0] RegExpiry       = 3'd3;
   localparam logic [2:0] RegWarnLevel    = 3'd4;

   typedef enum logic [1:0] {
      KIND_SUBMIT = 2'd0,
      KIND_UPDATE = 2'd1,
      KIND_STOP   = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_ACCEPTED  = 4'd0,
      ST_DUPLICATE = 4'd1,
      ST_FILTERED  = 4'd2,
      ST_FULL      = 4'd3,
      ST_EXECUTED  = 4'd4,
      ST_PREEMPTED = 4'd5,
      ST_BLOCKED   = 4'd6,
      ST_DROPPED   = 4'd7,
      ST_EMPTY     = 4'd8,
      ST_DONE      = 4'd9
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOKUP,
      S_SUBMIT,
      S_EXPIRE,
      S_ARB,
      S_SELECT,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
      logic select;
   } qcmd_type;

   typedef struct packed {
      logic lookup;
      logic expire;
      logic record;
   } dcmd_type;

   typedef struct packed {
      logic done;
      logic dup;
   } dstat_type;

endpackage
`default_nettype wire

/* hw/rtl/preemptive_priority_request_arbiter.sv */
// Top level of the preemptive priority request arbiter: register port,
// controller, current-request state and result register.
// Depends on ppra_pkg, ppra_dedup and ppra_queue.
//
// Usage: one transaction on the req_ channel (submit, update tick, stop all
// or clear pending) gives exactly one transaction on the rsp_ channel.
// The block handles one item at a time; req_stall is high while it works.
// Path of each item:
//   stop / clear : straight through arbitration to the result register.
//   submit       : a recent-key scan with duplicate detection on
//                  (one key/stamp memory read per cycle), then the checks.
//   update tick  : a key expiry scan (skipped when disabled), then
//                  the priority select over the pending entries, one entry
//                  memory read per cycle (none when nothing is pending).
// The result waits in an output register; while rsp_stall is high it holds
// and the next item may already be taken and worked on, stopping only at
// its own result. Reset empties the queue, the recent-key table and the
// current request, and loads the register defaults. Unenforced rule: write
// configuration through the APB-style port while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module preemptive_priority_request_arbiter #(
   parameter int QUEUE_DEPTH = ppra_pkg::DefQueueDepth,
   parameter int DEDUP_DEPTH = ppra_pkg::DefDedupDepth,
   parameter int TAG_BITS    = ppra_pkg::DefTagBits
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [1:0]                        req_kind,
   input  wire logic [ppra_pkg::TimeW-1:0]        req_now_ms,
   input  wire logic [ppra_pkg::PrioW-1:0]        req_priority_req,
   input  wire logic                              req_interruptible,
   input  wire logic [ppra_pkg::KeyW-1:0]         req_request_key,
   input  wire logic [ppra_pkg::TypeW-1:0]        req_move_type,
   input  wire logic [ppra_pkg::FieldTagW-1:0]    req_request_tag,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [3:0]                             rsp_status,
   output logic                                   rsp_exec_valid,
   output logic [ppra_pkg::FieldTagW-1:0]         rsp_exec_tag,
   output logic [ppra_pkg::TypeW-1:0]             rsp_exec_type,
   output logic [ppra_pkg::PrioW-1:0]             rsp_exec_priority,
   output logic [4:0]                             rsp_pending_count,
   output logic                                   rsp_queue_warning,
   output logic                                   rsp_current_valid,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [ppra_pkg::AddrW-1:0]        paddr,
   input  wire logic [ppra_pkg::DataW-1:0]        pwdata,
   output logic [ppra_pkg::DataW-1:0]             prdata,
   output logic                                   pready
);
   import ppra_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   // Configuration registers
   logic              dedup_en_ff, filter_en_ff;
   logic [GapW-1:0]   gap_ff, expiry_ff;
   logic [LevelW-1:0] warn_ff;
   logic              cfg_wr;

   // Controller
   state_type         state_ff, state_in;
   kind_type          kind_ff;
   logic [TimeW-1:0]  now_ff;
   logic [PrioW-1:0]  prio_ff;
   logic              intr_ff;
   logic [KeyW-1:0]   key_ff;
   logic [TypeW-1:0]  type_ff;
   logic [TAG_BITS-1:0] tag_ff, tag_in;
   logic [31:0]       tag_wide, win_tag_wide;

   // Current request
   logic              cur_valid_ff, cur_valid_in;
   logic [PrioW-1:0]  cur_prio_ff, cur_prio_in;
   logic              cur_intr_ff, cur_intr_in;

   // Staged result
   status_type        res_status_ff, res_status_in;
   logic              res_exec_ff, res_exec_in;
   logic [FieldTagW-1:0] res_tag_ff, res_tag_in;
   logic [TypeW-1:0]  res_type_ff, res_type_in;
   logic [PrioW-1:0]  res_prio_ff, res_prio_in;

   logic              accept, load_out;
   qcmd_type          qcmd;
   dcmd_type          dcmd;
   dstat_type         dstat;
   logic [CW-1:0]     q_count;
   logic              q_done, win_intr;
   logic [PrioW-1:0]  win_prio;
   logic [TypeW-1:0]  win_type;
   logic [TAG_BITS-1:0] win_tag;

   // Register port
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         dedup_en_ff  <= 1'b1;
         filter_en_ff <= 1'b1;
         gap_ff       <= GapW'(500);
         expiry_ff    <= GapW'(5000);
         warn_ff      <= LevelW'(10);
      end else if (cfg_wr) begin
         unique case (paddr[4:2])
            RegDedupEnable:  dedup_en_ff  <= pwdata[0];
            RegFilterEnable: filter_en_ff <= pwdata[0];
            RegDupGap:       gap_ff       <= pwdata[GapW-1:0];
            RegExpiry:       expiry_ff    <= pwdata[GapW-1:0];
            RegWarnLevel:    warn_ff      <= pwdata[LevelW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         RegDedupEnable:  prdata = DataW'(dedup_en_ff);
         RegFilterEnable: prdata = DataW'(filter_en_ff);
         RegDupGap:       prdata = DataW'(gap_ff);
         RegExpiry:       prdata = DataW'(expiry_ff);
         RegWarnLevel:    prdata = DataW'(warn_ff);
         default:         prdata = '0;
      endcase
   end

   // Keep the low TAG_BITS of the tag field; zero-extend when wider
   assign tag_wide     = 32'(req_request_tag);
   assign tag_in       = tag_wide[TAG_BITS-1:0];
   assign win_tag_wide = 32'(win_tag);

   ppra_dedup #(.DEDUP_DEPTH(DEDUP_DEPTH)) u_dedup (
      .clock (clock),
      .reset (reset),
      .cmd   (dcmd),
      .key   (key_ff),
      .now   (now_ff),
      .gap   (gap_ff),
      .expiry(expiry_ff),
      .stat  (dstat)
   );

   ppra_queue #(.QUEUE_DEPTH(QUEUE_DEPTH), .TAG_BITS(TAG_BITS)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .cmd     (qcmd),
      .in_prio (prio_ff),
      .in_intr (intr_ff),
      .in_type (type_ff),
      .in_tag  (tag_ff),
      .count   (q_count),
      .sel_done(q_done),
      .win_prio(win_prio),
      .win_intr(win_intr),
      .win_type(win_type),
      .win_tag (win_tag)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign load_out  = (state_ff == S_FINISH) && (!rsp_valid || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // Next state, commands and result staging
   always_comb begin
      state_in      = state_ff;
      qcmd          = '0;
      dcmd          = '0;
      cur_valid_in  = cur_valid_ff;
      cur_prio_in   = cur_prio_ff;
      cur_intr_in   = cur_intr_ff;
      res_status_in = res_status_ff;
      res_exec_in   = res_exec_ff;
      res_tag_in    = res_tag_ff;
      res_type_in   = res_type_ff;
      res_prio_in   = res_prio_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_exec_in = 1'b0;
               res_tag_in  = '0;
               res_type_in = '0;
               res_prio_in = '0;
               unique case (kind_type'(req_kind))
                  KIND_SUBMIT: state_in = S_LOOKUP;
                  KIND_UPDATE: state_in = S_EXPIRE;
                  KIND_STOP, KIND_CLEAR: state_in = S_ARB;
                  default: ;
               endcase
            end
         end
         S_LOOKUP: begin
            // Wait for the key scan started on acceptance; skip it when dedup is off
            if (!dedup_en_ff) begin
               state_in = S_SUBMIT;
            end else if (dstat.done) begin
               state_in = S_SUBMIT;
            end
         end
         S_SUBMIT: begin
            if (dedup_en_ff && dstat.dup) begin
               res_status_in = ST_DUPLICATE;
            end else if (filter_en_ff && cur_valid_ff && prio_ff < cur_prio_ff) begin
               res_status_in = ST_FILTERED;
            end else if (q_count >= CW'(QUEUE_DEPTH)) begin
               res_status_in = ST_FULL;
            end else begin
               qcmd.push     = 1'b1;
               dcmd.record   = dedup_en_ff;
               res_status_in = ST_ACCEPTED;
            end
            state_in = S_FINISH;
         end
         S_EXPIRE: begin
            if (!dedup_en_ff || dstat.done) state_in = S_ARB;
         end
         S_ARB: begin
            if (kind_ff == KIND_STOP || kind_ff == KIND_CLEAR) begin
               // Drop all pending; stop also drops the current request
               qcmd.clear    = 1'b1;
               res_status_in = ST_DONE;
               if (kind_ff == KIND_STOP) begin
                  cur_valid_in = 1'b0;
                  cur_prio_in  = '0;
                  cur_intr_in  = 1'b0;
               end
               state_in = S_FINISH;
            end else if (q_count == '0) begin
               res_status_in = ST_EMPTY;
               state_in      = S_FINISH;
            end else begin
               qcmd.select = 1'b1;
               state_in    = S_SELECT;
            end
         end
         S_SELECT: begin
            if (q_done) begin
               if (cur_valid_ff && win_prio > cur_prio_ff && !cur_intr_ff) begin
                  res_status_in = ST_BLOCKED;
               end else if (cur_valid_ff && win_prio <= cur_prio_ff) begin
                  qcmd.pop      = 1'b1;
                  res_status_in = ST_DROPPED;
               end else begin
                  qcmd.pop      = 1'b1;
                  res_status_in = cur_valid_ff ? ST_PREEMPTED : ST_EXECUTED;
                  res_exec_in   = 1'b1;
                  res_tag_in    = win_tag_wide[FieldTagW-1:0];
                  res_type_in   = win_type;
                  res_prio_in   = win_prio;
                  cur_valid_in  = 1'b1;
                  cur_prio_in   = win_prio;
                  cur_intr_in   = win_intr;
               end
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (load_out) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      // Kick the dedup scans in the cycle the item is accepted
      if (accept && dedup_en_ff) begin
         dcmd.lookup = (kind_type'(req_kind) == KIND_SUBMIT);
         dcmd.expire = (kind_type'(req_kind) == KIND_UPDATE);
      end
   end

   // Latch the item on acceptance
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= kind_type'(req_kind);
         now_ff  <= req_now_ms;
         prio_ff <= req_priority_req;
         intr_ff <= req_interruptible;
         key_ff  <= req_request_key;
         type_ff <= req_move_type;
         tag_ff  <= tag_in;
      end
      res_status_ff <= res_status_in;
      res_exec_ff   <= res_exec_in;
      res_tag_ff    <= res_tag_in;
      res_type_ff   <= res_type_in;
      res_prio_ff   <= res_prio_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         cur_prio_ff  <= '0;
         cur_intr_ff  <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         cur_prio_ff  <= cur_prio_in;
         cur_intr_ff  <= cur_intr_in;
      end
   end

   // Result register: advance when empty or when the receiver takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (load_out) begin
         rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_status        <= res_status_ff;
         rsp_exec_valid    <= res_exec_ff;
         rsp_exec_tag      <= res_tag_ff;
         rsp_exec_type     <= res_type_ff;
         rsp_exec_priority <= res_prio_ff;
         rsp_pending_count <= 5'(q_count);
         rsp_queue_warning <= (8'(q_count) > 8'(warn_ff));
         rsp_current_valid <= cur_valid_ff;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/ppra_dedup.sv */
// Recent-key table: one key/stamp memory, valid flops and a sequential scan.
// Depends on ppra_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ppra_dedup #(
   parameter int DEDUP_DEPTH = ppra_pkg::DefDedupDepth
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire ppra_pkg::dcmd_type        cmd,
   input  wire logic [ppra_pkg::KeyW-1:0] key,
   input  wire logic [ppra_pkg::TimeW-1:0] now,
   input  wire logic [ppra_pkg::GapW-1:0] gap,
   input  wire logic [ppra_pkg::GapW-1:0] expiry,
   output ppra_pkg::dstat_type            stat
);
   import ppra_pkg::*;

   localparam int IW = (DEDUP_DEPTH > 1) ? $clog2(DEDUP_DEPTH) : 1;
   localparam int CW = $clog2(DEDUP_DEPTH + 1);
   localparam int MW = KeyW + TimeW;

   logic [MW-1:0]          mem_ff [DEDUP_DEPTH];
   logic [MW-1:0]          rd_ff;
   logic [DEDUP_DEPTH-1:0] valid_ff;
   logic                   scan_ff, expire_ff, rv_ff, hit_ff, dup_ff, first_ff;
   logic [CW-1:0]          idx_ff;
   logic [IW-1:0]          ridx_ff, hit_idx_ff, max_idx_ff, free_idx;
   logic [TimeW-1:0]       best_ff, age;
   logic                   any_free, done;
   logic [IW-1:0]          slot;

   assign age  = now - rd_ff[TimeW-1:0];
   assign done = scan_ff && (idx_ff == CW'(DEDUP_DEPTH)) && !rv_ff;
   assign stat = '{done: done, dup: dup_ff};

   always_comb begin
      free_idx = '0;
      any_free = 1'b0;
      for (int i = DEDUP_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_idx = IW'(i);
            any_free = 1'b1;
         end
      end
      slot = hit_ff ? hit_idx_ff : (any_free ? free_idx : max_idx_ff);
   end

   always_ff @(posedge clock) begin
      if (scan_ff && idx_ff != CW'(DEDUP_DEPTH)) begin
         rd_ff <= mem_ff[idx_ff[IW-1:0]];
      end
      if (cmd.record) begin
         mem_ff[slot] <= {key, now};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         scan_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         if (cmd.lookup || cmd.expire) begin
            scan_ff   <= 1'b1;
            expire_ff <= cmd.expire;
            idx_ff    <= '0;
            hit_ff    <= 1'b0;
            dup_ff    <= 1'b0;
            first_ff  <= 1'b1;
            rv_ff     <= 1'b0;
         end else if (scan_ff) begin
            if (idx_ff != CW'(DEDUP_DEPTH)) begin
               rv_ff   <= 1'b1;
               ridx_ff <= idx_ff[IW-1:0];
               idx_ff  <= idx_ff + CW'(1);
            end else begin
               rv_ff <= 1'b0;
            end
            if (rv_ff) begin
               if (expire_ff) begin
                  if (valid_ff[ridx_ff] && age > TimeW'(expiry)) valid_ff[ridx_ff] <= 1'b0;
               end else begin
                  if (valid_ff[ridx_ff] && rd_ff[MW-1:TimeW] == key && !hit_ff) begin
                     hit_ff     <= 1'b1;
                     hit_idx_ff <= ridx_ff;
                     dup_ff     <= age < TimeW'(gap);
                  end
                  if (first_ff || age > best_ff) begin
                     best_ff    <= age;
                     max_idx_ff <= ridx_ff;
                  end
                  first_ff <= 1'b0;
               end
            end
            if (done) scan_ff <= 1'b0;
         end
         if (cmd.record) valid_ff[slot] <= 1'b1;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/ppra_queue.sv */
// Pending queue: entry memory indexed by slot, age-order list of slots,
// and a sequential highest-priority select. Depends on ppra_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ppra_queue #(
   parameter int QUEUE_DEPTH = ppra_pkg::DefQueueDepth,
   parameter int TAG_BITS    = ppra_pkg::DefTagBits
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire ppra_pkg::qcmd_type            cmd,
   input  wire logic [ppra_pkg::PrioW-1:0]    in_prio,
   input  wire logic                          in_intr,
   input  wire logic [ppra_pkg::TypeW-1:0]    in_type,
   input  wire logic [TAG_BITS-1:0]           in_tag,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]   count,
   output logic                               sel_done,
   output logic [ppra_pkg::PrioW-1:0]         win_prio,
   output logic                               win_intr,
   output logic [ppra_pkg::TypeW-1:0]         win_type,
   output logic [TAG_BITS-1:0]                win_tag
);
   import ppra_pkg::*;

   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = PrioW + 1 + TypeW + TAG_BITS;

   logic [EW-1:0] mem_ff [QUEUE_DEPTH];
   logic [EW-1:0] rd_ff, best_ff;
   logic [IW-1:0] order_ff [QUEUE_DEPTH];
   logic [CW-1:0] count_ff, pos_ff;
   logic [IW-1:0] rpos_ff, best_pos_ff, rm_slot;
   logic          scan_ff, rv_ff, first_ff;

   assign count    = count_ff;
   assign sel_done = scan_ff && (pos_ff == count_ff) && !rv_ff;
   assign win_tag  = best_ff[TAG_BITS-1:0];
   assign win_type = best_ff[TAG_BITS+TypeW-1:TAG_BITS];
   assign win_intr = best_ff[TAG_BITS+TypeW];
   assign win_prio = best_ff[EW-1:EW-PrioW];
   assign rm_slot  = order_ff[best_pos_ff];

   always_ff @(posedge clock) begin
      if (scan_ff && pos_ff != count_ff) begin
         rd_ff <= mem_ff[order_ff[pos_ff[IW-1:0]]];
      end
      if (cmd.push) begin
         mem_ff[order_ff[count_ff[IW-1:0]]] <= {in_prio, in_intr, in_type, in_tag};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         scan_ff  <= 1'b0;
         rv_ff    <= 1'b0;
         for (int j = 0; j < QUEUE_DEPTH; j++) order_ff[j] <= IW'(j);
      end else begin
         if (cmd.select) begin
            scan_ff  <= 1'b1;
            pos_ff   <= '0;
            first_ff <= 1'b1;
            rv_ff    <= 1'b0;
         end else if (scan_ff) begin
            if (pos_ff != count_ff) begin
               rv_ff   <= 1'b1;
               rpos_ff <= pos_ff[IW-1:0];
               pos_ff  <= pos_ff + CW'(1);
            end else begin
               rv_ff <= 1'b0;
            end
            if (rv_ff && (first_ff || rd_ff[EW-1:EW-PrioW] > best_ff[EW-1:EW-PrioW])) begin
               best_ff     <= rd_ff;
               best_pos_ff <= rpos_ff;
            end
            if (rv_ff) first_ff <= 1'b0;
            if (sel_done) scan_ff <= 1'b0;
         end
         if (cmd.clear) begin
            count_ff <= '0;
         end else if (cmd.push) begin
            count_ff <= count_ff + CW'(1);
         end else if (cmd.pop) begin
            count_ff <= count_ff - CW'(1);
            for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
               if (IW'(j) >= best_pos_ff) order_ff[j] <= order_ff[j+1];
            end
            order_ff[QUEUE_DEPTH-1] <= rm_slot;
         end
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/ppra_checker.sv */
// Port-level checker for the arbiter and its bind to the top level.
// Depends on ppra_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ppra_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [3:0] rsp_status,
   input wire logic       rsp_exec_valid,
   input wire logic [15:0] rsp_exec_tag,
   input wire logic [4:0] rsp_pending_count,
   input wire logic       rsp_current_valid
);
   import ppra_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_exec_tag))
      else $error("result changed while stalled");

   a_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_exec_valid |->
         (rsp_status == ST_EXECUTED || rsp_status == ST_PREEMPTED) && rsp_current_valid)
      else $error("issued request without execute status");

   a_noexec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_exec_valid |-> rsp_exec_tag == '0)
      else $error("exec tag not zero without issue");

   a_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_DONE |-> rsp_pending_count == '0)
      else $error("pending left after stop or clear");

endmodule

bind preemptive_priority_request_arbiter ppra_checker u_ppra_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_exec_valid   (rsp_exec_valid),
   .rsp_exec_tag     (rsp_exec_tag),
   .rsp_pending_count(rsp_pending_count),
   .rsp_current_valid(rsp_current_valid)
);
`default_nettype wire

/* tb/sv/arbiter_checker.sv */
// Checker for the preemptive priority request arbiter: watches the req_, rsp_ and
// register-port transactions, predicts each result and compares it field by field.
// Depends on ppra_pkg.
`timescale 1ns / 1ps
module arbiter_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_now_ms,
   input  logic [7:0]  req_priority_req,
   input  logic        req_interruptible,
   input  logic [63:0] req_request_key,
   input  logic [2:0]  req_move_type,
   input  logic [15:0] req_request_tag,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [3:0]  rsp_status,
   input  logic        rsp_exec_valid,
   input  logic [15:0] rsp_exec_tag,
   input  logic [2:0]  rsp_exec_type,
   input  logic [7:0]  rsp_exec_priority,
   input  logic [4:0]  rsp_pending_count,
   input  logic        rsp_queue_warning,
   input  logic        rsp_current_valid,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          outstanding
);
   import ppra_pkg::*;

   localparam int QueueDepth = 16;
   localparam int KeySlots   = 16;

   typedef struct {
      logic [7:0]  prio;
      logic        intr;
      logic [2:0]  mtype;
      logic [15:0] tag;
   } waiting_req_type;

   typedef struct {
      status_type  status;
      logic        exec_valid;
      logic [15:0] exec_tag;
      logic [2:0]  exec_type;
      logic [7:0]  exec_prio;
      logic [4:0]  pcount;
      logic        warn;
      logic        curv;
   } outcome_type;

   waiting_req_type waiting_reqs[$];
   outcome_type     expected_outcomes[$];
   logic [63:0]  seen_key[KeySlots];
   logic [31:0]  seen_stamp[KeySlots];
   logic [KeySlots-1:0] seen_ok;
   logic        cur_valid;
   logic [7:0]  cur_prio;
   logic        cur_intr;
   logic        dedup_on;
   logic        filter_on;
   logic [15:0] dup_gap;
   logic [15:0] expiry;
   logic [4:0]  warn_level;
   int          errs;

   function automatic int key_slot(logic [63:0] key);
      for (int i = 0; i < KeySlots; i++)
         if (seen_ok[i] && seen_key[i] == key) return i;
      return -1;
   endfunction

   task automatic record_key(logic [63:0] key, logic [31:0] now);
      int hit;
      int slot;
      logic [31:0] best;
      logic [31:0] age;
      hit = key_slot(key);
      slot = -1;
      best = 0;
      if (hit >= 0) begin
         seen_stamp[hit] = now;
         return;
      end
      for (int i = 0; i < KeySlots; i++)
         if (!seen_ok[i] && slot < 0) slot = i;
      // table full: evict the stalest entry, lowest slot on ties
      if (slot < 0) begin
         for (int i = 0; i < KeySlots; i++) begin
            age = now - seen_stamp[i];
            if (i == 0 || age > best) begin
               best = age;
               slot = i;
            end
         end
      end
      seen_key[slot] = key;
      seen_stamp[slot] = now;
      seen_ok[slot] = 1'b1;
   endtask

   task automatic arbitrate_item(output outcome_type o);
      int hit;
      int w;
      logic [31:0] age;
      waiting_req_type req;
      waiting_req_type win;
      req = '{req_priority_req, req_interruptible, req_move_type, req_request_tag};
      win = '{8'd0, 1'b0, 3'd0, 16'd0};
      o.exec_valid = 1'b0;
      case (kind_type'(req_kind))
         KIND_SUBMIT: begin
            hit = dedup_on ? key_slot(req_request_key) : -1;
            age = (hit >= 0) ? req_now_ms - seen_stamp[hit] : 32'd0;
            if (hit >= 0 && age < {16'd0, dup_gap}) begin
               o.status = ST_DUPLICATE;
            end else if (filter_on && cur_valid && req.prio < cur_prio) begin
               o.status = ST_FILTERED;
            end else if (waiting_reqs.size() >= QueueDepth) begin
               o.status = ST_FULL;
            end else begin
               waiting_reqs = {waiting_reqs, req};
               if (dedup_on) record_key(req_request_key, req_now_ms);
               o.status = ST_ACCEPTED;
            end
         end
         KIND_UPDATE: begin
            if (dedup_on)
               for (int i = 0; i < KeySlots; i++)
                  if (seen_ok[i] && (req_now_ms - seen_stamp[i]) > {16'd0, expiry})
                     seen_ok[i] = 1'b0;
            if (waiting_reqs.size() == 0) begin
               o.status = ST_EMPTY;
            end else begin
               w = 0;
               for (int i = 1; i < waiting_reqs.size(); i++)
                  if (waiting_reqs[i].prio > waiting_reqs[w].prio) w = i;
               win = waiting_reqs[w];
               if (cur_valid && win.prio > cur_prio && !cur_intr) begin
                  o.status = ST_BLOCKED;
               end else if (cur_valid && win.prio <= cur_prio) begin
                  waiting_reqs.delete(w);
                  o.status = ST_DROPPED;
               end else begin
                  o.status = cur_valid ? ST_PREEMPTED : ST_EXECUTED;
                  waiting_reqs.delete(w);
                  cur_valid = 1'b1;
                  cur_prio = win.prio;
                  cur_intr = win.intr;
                  o.exec_valid = 1'b1;
               end
            end
         end
         default: begin
            waiting_reqs.delete();
            if (kind_type'(req_kind) == KIND_STOP) begin
               cur_valid = 1'b0;
               cur_prio = 0;
               cur_intr = 0;
            end
            o.status = ST_DONE;
         end
      endcase
      o.exec_tag = o.exec_valid ? win.tag : 16'd0;
      o.exec_type = o.exec_valid ? win.mtype : 3'd0;
      o.exec_prio = o.exec_valid ? win.prio : 8'd0;
      o.pcount = 5'(waiting_reqs.size());
      o.warn = waiting_reqs.size() > warn_level;
      o.curv = cur_valid;
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         errs++;
      end
   endtask

   initial begin
      errs = 0;
      fail_count = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      outcome_type o;
      if (reset) begin
         waiting_reqs.delete();
         expected_outcomes.delete();
         seen_ok = '0;
         cur_valid = 1'b0;
         cur_prio = 0;
         cur_intr = 0;
         dedup_on = 1'b1;
         filter_on = 1'b1;
         dup_gap = 16'd500;
         expiry = 16'd5000;
         warn_level = 5'd10;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               RegDedupEnable:  dedup_on = pwdata[0];
               RegFilterEnable: filter_on = pwdata[0];
               RegDupGap:       dup_gap = pwdata[15:0];
               RegExpiry:       expiry = pwdata[15:0];
               RegWarnLevel:    warn_level = pwdata[4:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_outcomes.size() == 0) begin
               $display("%0t: result with nothing expected, status %0d", $time, rsp_status);
               errs++;
            end else begin
               o = expected_outcomes[0];
               expected_outcomes.delete(0);
               check_field("status", o.status, rsp_status);
               check_field("exec_valid", o.exec_valid, rsp_exec_valid);
               check_field("exec_tag", o.exec_tag, rsp_exec_tag);
               check_field("exec_type", o.exec_type, rsp_exec_type);
               check_field("exec_priority", o.exec_prio, rsp_exec_priority);
               check_field("pending_count", o.pcount, rsp_pending_count);
               check_field("queue_warning", o.warn, rsp_queue_warning);
               check_field("current_valid", o.curv, rsp_current_valid);
            end
         end
         if (req_valid && !req_stall) begin
            arbitrate_item(o);
            expected_outcomes = {expected_outcomes, o};
         end
      end
      outstanding <= expected_outcomes.size();
      fail_count <= errs;
   end

endmodule

/* tb/sv/testbench.sv */
// Top of the arbiter testbench: clock, reset, stimulus, register writes and verdict.
// Depends on ppra_pkg, preemptive_priority_request_arbiter and arbiter_checker.
`timescale 1ns / 1ps
module testbench;
   import ppra_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_kind;
   logic [31:0] req_now_ms;
   logic [7:0]  req_priority_req;
   logic        req_interruptible;
   logic [63:0] req_request_key;
   logic [2:0]  req_move_type;
   logic [15:0] req_request_tag;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [3:0]  rsp_status;
   logic        rsp_exec_valid;
   logic [15:0] rsp_exec_tag;
   logic [2:0]  rsp_exec_type;
   logic [7:0]  rsp_exec_priority;
   logic [4:0]  rsp_pending_count;
   logic        rsp_queue_warning;
   logic        rsp_current_valid;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   int          fail_count;
   int          outstanding;
   int          items_sent;
   int          idle_cycles;
   bit          quiet;          // final stretch: no idling on either side
   bit          hold_request;   // ask the receiver for one long hold-off
   logic [31:0] sim_ms;
   logic [63:0] key_pool[12];

   preemptive_priority_request_arbiter uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_now_ms(req_now_ms), .req_priority_req(req_priority_req),
      .req_interruptible(req_interruptible), .req_request_key(req_request_key),
      .req_move_type(req_move_type), .req_request_tag(req_request_tag),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_exec_valid(rsp_exec_valid), .rsp_exec_tag(rsp_exec_tag),
      .rsp_exec_type(rsp_exec_type), .rsp_exec_priority(rsp_exec_priority),
      .rsp_pending_count(rsp_pending_count), .rsp_queue_warning(rsp_queue_warning),
      .rsp_current_valid(rsp_current_valid),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   arbiter_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_now_ms(req_now_ms), .req_priority_req(req_priority_req),
      .req_interruptible(req_interruptible), .req_request_key(req_request_key),
      .req_move_type(req_move_type), .req_request_tag(req_request_tag),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_exec_valid(rsp_exec_valid), .rsp_exec_tag(rsp_exec_tag),
      .rsp_exec_type(rsp_exec_type), .rsp_exec_priority(rsp_exec_priority),
      .rsp_pending_count(rsp_pending_count), .rsp_queue_warning(rsp_queue_warning),
      .rsp_current_valid(rsp_current_valid),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .fail_count(fail_count), .outstanding(outstanding)
   );

   // 20 ns period
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Watchdog: count cycles with no transaction on any port. The slowest
   // legitimate quiet stretch is the long receiver hold-off plus the settle
   // pause between phases, far below the limit.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= 4000) begin
         $display("[preemptive_priority_request_arbiter] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Receiver: random stall bursts, one long hold-off on request, none when quiet.
   initial begin
      int hold_count;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            // hold off long enough for the block to fill and stall its input
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            hold_count = 0;
            while (hold_count < 250) begin
               @(posedge clock);
               hold_count++;
            end
         end else if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   end

   // Offer one transaction and hold it until accepted; maybe idle afterwards.
   task automatic send_item(kind_type kind, logic [31:0] now, logic [7:0] prio,
                            logic intr, logic [63:0] key, logic [2:0] mtype,
                            logic [15:0] tag);
      req_valid <= 1'b1;
      req_kind <= kind;
      req_now_ms <= now;
      req_priority_req <= prio;
      req_interruptible <= intr;
      req_request_key <= key;
      req_move_type <= mtype;
      req_request_tag <= tag;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (items_sent == 120) hold_request = 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every expected result is in, then let the block drain.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (60) @(posedge clock);
   endtask

   // Setup cycle, access cycle; the register takes the value at the access edge.
   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Random transaction: keys mostly from a small pool so duplicates happen,
   // time mostly creeping forward with the odd jump across the wrap.
   task automatic send_random(int submit_pct);
      kind_type kind;
      int roll;
      logic [63:0] key;
      roll = $urandom_range(0, 99);
      if (roll < submit_pct) kind = KIND_SUBMIT;
      else if (roll < 94) kind = KIND_UPDATE;
      else if (roll < 97) kind = KIND_STOP;
      else kind = KIND_CLEAR;
      if ($urandom_range(0, 19) == 0) sim_ms = $urandom;
      else sim_ms = sim_ms + $urandom_range(0, 400);
      key = ($urandom_range(0, 9) < 7) ? key_pool[$urandom_range(0, 11)]
                                        : {$urandom, $urandom};
      send_item(kind, sim_ms, 8'($urandom), 1'($urandom), key, 3'($urandom),
                16'($urandom));
   endtask

   initial begin
      logic [31:0] gap_v;
      logic [31:0] exp_v;
      logic [31:0] warn_v;
      logic        dedup_v;
      logic        filter_v;
      int          heavy;
      reset = 1'b1;
      req_valid = 1'b0;
      req_kind = KIND_SUBMIT;
      req_now_ms = 0;
      req_priority_req = 0;
      req_interruptible = 0;
      req_request_key = 0;
      req_move_type = 0;
      req_request_tag = 0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = 0;
      pwdata = 0;
      items_sent = 0;
      idle_cycles = 0;
      quiet = 1'b0;
      hold_request = 1'b0;
      sim_ms = 0;
      key_pool[0] = 64'd0;
      key_pool[1] = '1;
      for (int i = 2; i < 12; i++) key_pool[i] = {$urandom, $urandom};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty tick, duplicate, extremes, filter, drop, block,
      // clear, preempt, known key past the gap across the time wrap.
      send_item(KIND_UPDATE, 32'd0, 8'd0, 1'b0, 64'd0, 3'd0, 16'd0);
      send_item(KIND_SUBMIT, 32'd0, 8'h10, 1'b0, 64'd0, 3'd0, 16'd0);
      send_item(KIND_SUBMIT, 32'd10, 8'h10, 1'b0, 64'd0, 3'd1, 16'd1);
      send_item(KIND_SUBMIT, 32'd20, 8'hff, 1'b1, '1, 3'd7, 16'hffff);
      send_item(KIND_UPDATE, 32'd30, 8'd0, 1'b0, 64'd0, 3'd0, 16'd0);
      send_item(KIND_SUBMIT, 32'd40, 8'h05, 1'b0, 64'd5, 3'd2, 16'd5);
      send_item(KIND_UPDATE, 32'd50, 8'd0, 1'b0, 64'd0, 3'd0, 16'd0);
      send_item(KIND_STOP, 32'd60, 8'hff, 1'b1, '1, 3'd7, 16'hffff);
      send_item(KIND_SUBMIT, 32'd100, 8'h20, 1'b0, 64'd9, 3'd5, 16'h1234);
      send_item(KIND_UPDATE, 32'd110, 8'd0, 1'b0, 64'd0, 3'd0, 16'd0);
      send_item(KIND_SUBMIT, 32'd200, 8'h40, 1'b1, 64'd11, 3'd6, 16'h8000);
      send_item(KIND_UPDATE, 32'd210, 8'd0, 1'b0, 64'd0, 3'd0, 16'd0);
      send_item(KIND_CLEAR, 32'd220, 8'd0, 1'b0, 64'd0, 3'd0, 16'd0);
      send_item(KIND_STOP, 32'd230, 8'd0, 1'b0, 64'd0, 3'd0, 16'd0);
      send_item(KIND_SUBMIT, 32'd240, 8'h30, 1'b1, 64'd13, 3'd3, 16'h0aaa);
      send_item(KIND_UPDATE, 32'd250, 8'd0, 1'b0, 64'd0, 3'd0, 16'd0);
      send_item(KIND_SUBMIT, 32'd260, 8'h90, 1'b1, 64'd14, 3'd4, 16'h5555);
      send_item(KIND_UPDATE, 32'd270, 8'd0, 1'b0, 64'd0, 3'd0, 16'd0);
      send_item(KIND_SUBMIT, 32'hffff_ffff, 8'ha0, 1'b1, 64'd0, 3'd1, 16'h7777);
      send_item(KIND_UPDATE, 32'd0, 8'd0, 1'b0, 64'd0, 3'd0, 16'd0);
      send_item(KIND_STOP, 32'd5, 8'd0, 1'b0, 64'd0, 3'd0, 16'd0);
      settle();

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin dedup_v = 1; filter_v = 1; gap_v = 500; exp_v = 5000; warn_v = 10; end
            1: begin dedup_v = 1; filter_v = 1; gap_v = 0; exp_v = 0; warn_v = 0; end
            2: begin dedup_v = 1; filter_v = 0; gap_v = 65535; exp_v = 65535; warn_v = 16; end
            3: begin dedup_v = 0; filter_v = 1; gap_v = $urandom_range(0, 65535);
               exp_v = $urandom_range(0, 65535); warn_v = $urandom_range(0, 16); end
            4: begin dedup_v = 1; filter_v = 1; gap_v = $urandom_range(0, 2000);
               exp_v = $urandom_range(0, 8000); warn_v = $urandom_range(0, 16); end
            5: begin dedup_v = 0; filter_v = 0; gap_v = 65535; exp_v = 0; warn_v = 16; end
            6: begin dedup_v = 1; filter_v = 1; gap_v = 65535; exp_v = 0; warn_v = 5; end
            default: begin dedup_v = 1; filter_v = $urandom_range(0, 1);
               gap_v = $urandom_range(0, 65535); exp_v = $urandom_range(0, 65535);
               warn_v = $urandom_range(0, 16); end
         endcase
         csr_write(RegDedupEnable, 32'(dedup_v));
         csr_write(RegFilterEnable, 32'(filter_v));
         csr_write(RegDupGap, gap_v);
         csr_write(RegExpiry, exp_v);
         csr_write(RegWarnLevel, warn_v);
         // alternate between submit-heavy phases (fill the queue and the key
         // table) and balanced ones
         heavy = (phase % 2 == 0) ? 80 : 55;
         if (phase == 7) quiet = 1'b1;
         for (int n = 0; n < 55; n++) send_random(heavy);
         settle();
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("[preemptive_priority_request_arbiter] OK");
      end else begin
         $display("[preemptive_priority_request_arbiter] ERROR");
      end
      $finish;
   end

endmodule

/* preemptive_priority_request_arbiter.f */
hw/rtl/ppra_pkg.sv
hw/rtl/ppra_dedup.sv
hw/rtl/ppra_queue.sv
hw/rtl/preemptive_priority_request_arbiter.sv
hw/rtl/ppra_checker.sv
tb/sv/arbiter_checker.sv
tb/sv/testbench.sv
